// ===== rtl/sts_pkg.sv =====
// ----------------------------------------------------------------------------
// sts_pkg
// Shared widths, register codes, reset values and the sine table builder
// for the sine tone envelope synthesizer.
// ----------------------------------------------------------------------------
package sts_pkg;

   // table and phase accumulator geometry (table depth is a power of two)
   localparam int SINE_ENTRIES = 1024;
   localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
   localparam int PHASE_BITS   = 32;

   // field widths
   localparam int PHASE_STEP_W = 32;
   localparam int CFG_W        = 16;
   localparam int LEVEL_W      = 24;
   localparam int SAMPLE_W     = 16;
   localparam int MAG_W        = SAMPLE_W - 1;
   localparam int PROD_W       = MAG_W + LEVEL_W;
   localparam int PROD_SHIFT   = 23;
   localparam int SCALED_W     = PROD_W - PROD_SHIFT;

   localparam logic [LEVEL_W-1:0]  LEVEL_MAX  = {LEVEL_W{1'b1}};
   localparam logic [SCALED_W-1:0] POS_LIMIT  = SCALED_W'(32767);
   localparam logic [SCALED_W-1:0] NEG_LIMIT  = SCALED_W'(32768);
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   // configuration port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = CFG_W;
   localparam logic [CSR_INDEX_W-1:0] CSR_NOTE_LENGTH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENV_STEP    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_LEVEL = 2'd2;

   localparam logic [CFG_W-1:0] NOTE_LENGTH_RST = 16'd20000;
   localparam logic [CFG_W-1:0] ENV_STEP_RST    = 16'd307;
   localparam logic [CFG_W-1:0] START_LEVEL_RST = 16'd307;

   // registered stages from accept to the result register
   localparam int PIPE_DEPTH = 3;
   localparam int PIPE_CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

   // angle constants in Q30
   localparam longint unsigned PI_Q30     = 64'd3373259426;
   localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
   localparam int SINE_TERMS = 7;

   // taylor term divisors (2n)(2n+1) for n = 1 .. SINE_TERMS
   localparam longint unsigned TAYLOR_DIV [SINE_TERMS] =
      '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};

   typedef logic signed [SAMPLE_W-1:0] sine_tab_type [SINE_ENTRIES];

   // per-item values handed from the envelope to the scaling pipeline
   typedef struct packed {
      logic [SINE_BITS-1:0] addr;
      logic [LEVEL_W-1:0]   level;
      logic                 active;
      logic                 done;
   } sts_front_type;

   // Q1.15 sine of entry k: quadrant fold and odd Taylor terms in Q30
   function automatic logic signed [SAMPLE_W-1:0] sine_q15(input int unsigned k);
      longint unsigned a;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned mag;
      longint          sum;
      logic            neg;
      logic signed [SAMPLE_W-1:0] r;
      a   = (longint'(k) * TWO_PI_Q30) / SINE_ENTRIES;
      neg = 1'b0;
      if (a >= PI_Q30) begin
         a   = a - PI_Q30;
         neg = 1'b1;
      end
      if (a > PI_Q30 / 2) begin
         a = PI_Q30 - a;
      end
      x2   = (a * a) >> 30;
      term = a;
      sum  = longint'(a);
      for (int n = 1; n <= SINE_TERMS; n++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
         if (n % 2 == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      mag = (longint'(sum) + 64'd16384) >> 15;
      if (mag > 64'd32767) begin
         mag = 64'd32767;
      end
      r = SAMPLE_W'(mag);
      if (neg) begin
         r = -r;
      end
      return r;
   endfunction

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type t;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         t[k] = sine_q15(k);
      end
      return t;
   endfunction

endpackage

// ===== rtl/sts_if.sv =====
// ----------------------------------------------------------------------------
// sts_req_if / sts_rsp_if
// Valid/ready channels for tick requests and sample responses.
// ----------------------------------------------------------------------------
interface sts_req_if import sts_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    note_start;
   logic [PHASE_STEP_W-1:0] phase_step;

   modport source (output valid, output note_start, output phase_step, input ready);
   modport sink   (input valid, input note_start, input phase_step, output ready);
endinterface

interface sts_rsp_if import sts_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic                       note_done;

   modport source (output valid, output sample, output note_done, input ready);
   modport sink   (input valid, input sample, input note_done, output ready);
endinterface

// ===== rtl/sts_envelope.sv =====
// ----------------------------------------------------------------------------
// sts_envelope
// Configuration registers, phase accumulator, sample counter and the
// four-phase envelope level; produces the table address and the level of
// the sample being formed.
// ----------------------------------------------------------------------------
module sts_envelope import sts_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    note_start,
   input  logic [PHASE_STEP_W-1:0] phase_step,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata,
   output sts_front_type           front
);

   logic [CFG_W-1:0]      note_length_ff;
   logic [CFG_W-1:0]      env_step_ff;
   logic [CFG_W-1:0]      start_level_ff;

   logic [PHASE_BITS-1:0] phase_acc_ff, phase_acc_in;
   logic [PHASE_BITS-1:0] held_step_ff, held_step_in;
   logic [CFG_W-1:0]      sample_index_ff, sample_index_in;
   logic [LEVEL_W-1:0]    env_level_ff, env_level_in;
   logic                  note_active_ff, note_active_in;

   logic [CFG_W-1:0]      q1, q2, q3;
   logic [CFG_W+1:0]      len3;
   logic [CFG_W-2:0]      half;
   logic [LEVEL_W:0]      rise_sum;
   logic [LEVEL_W-1:0]    rise_lv, fall_lv, used_lv;
   logic                  done;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_length_ff <= NOTE_LENGTH_RST;
         env_step_ff    <= ENV_STEP_RST;
         start_level_ff <= START_LEVEL_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_NOTE_LENGTH: note_length_ff <= csr_wdata;
            CSR_ENV_STEP:    env_step_ff    <= csr_wdata;
            CSR_START_LEVEL: start_level_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // quarter bounds of the note
   assign q1   = note_length_ff >> 2;
   assign q2   = note_length_ff >> 1;
   assign len3 = {2'b00, note_length_ff} + {1'b0, note_length_ff, 1'b0};
   assign q3   = len3[CFG_W+1:2];
   assign half = env_step_ff[CFG_W-1:1];

   always_comb begin
      // a note start restarts everything on this same tick
      if (note_start) begin
         phase_acc_in    = '0;
         held_step_in    = PHASE_BITS'(phase_step);
         sample_index_in = '0;
         env_level_in    = LEVEL_W'(start_level_ff);
         note_active_in  = 1'b1;
      end else begin
         phase_acc_in    = phase_acc_ff;
         held_step_in    = held_step_ff;
         sample_index_in = sample_index_ff;
         env_level_in    = env_level_ff;
         note_active_in  = note_active_ff;
      end
      rise_sum = {1'b0, env_level_in} + (LEVEL_W+1)'(env_step_ff);
      rise_lv  = rise_sum[LEVEL_W] ? LEVEL_MAX : rise_sum[LEVEL_W-1:0];
      fall_lv  = (env_level_in > LEVEL_W'(half)) ? env_level_in - LEVEL_W'(half) : '0;
      done     = sample_index_in >= note_length_ff;
   end

   // level used by this sample and the level carried to the next one
   logic [LEVEL_W-1:0] next_lv;
   always_comb begin
      priority if (sample_index_in <= q1) begin
         used_lv = env_level_in;
         next_lv = rise_lv;
      end else if (sample_index_in <= q2) begin
         used_lv = fall_lv;
         next_lv = fall_lv;
      end else if (sample_index_in <= q3) begin
         used_lv = env_level_in;
         next_lv = env_level_in;
      end else begin
         used_lv = fall_lv;
         next_lv = fall_lv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff    <= '0;
         held_step_ff    <= '0;
         sample_index_ff <= '0;
         env_level_ff    <= '0;
         note_active_ff  <= 1'b0;
      end else if (accept && note_active_in) begin
         phase_acc_ff    <= phase_acc_in + held_step_in;
         held_step_ff    <= held_step_in;
         sample_index_ff <= done ? sample_index_in : sample_index_in + CFG_W'(1);
         env_level_ff    <= next_lv;
         note_active_ff  <= !done;
      end
   end

   assign front.addr   = phase_acc_in[PHASE_BITS-1 -: SINE_BITS];
   assign front.level  = used_lv;
   assign front.active = note_active_in;
   assign front.done   = note_active_in && done;

endmodule

// ===== rtl/sts_sine_rom.sv =====
// ----------------------------------------------------------------------------
// sts_sine_rom
// Full-wave Q1.15 sine table with a registered read port.
// ----------------------------------------------------------------------------
module sts_sine_rom import sts_pkg::*; (
   input  logic                       clock,
   input  logic                       rd_en,
   input  logic [SINE_BITS-1:0]       addr,
   output logic signed [SAMPLE_W-1:0] rd_data
);

   localparam sine_tab_type SINE_TAB = build_sine_tab();

   logic signed [SAMPLE_W-1:0] data_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         data_ff <= SINE_TAB[addr];
      end
   end

   assign rd_data = data_ff;

endmodule

// ===== rtl/sts_scale.sv =====
// ----------------------------------------------------------------------------
// sts_scale
// Pipeline from the table read to the result register: magnitude times
// level, truncation toward zero and saturation to 16 bits.
// ----------------------------------------------------------------------------
module sts_scale import sts_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  sts_front_type              front,
   input  logic signed [SAMPLE_W-1:0] sine,
   output logic                       s1_ready,
   sts_rsp_if.source                  rsp_ch
);

   // stage 1: table data (held by the rom) and sideband
   logic                 v1_ff;
   logic [LEVEL_W-1:0]   level1_ff;
   logic                 active1_ff, done1_ff;
   // stage 2: product
   logic                 v2_ff;
   logic [PROD_W-1:0]    prod2_ff, prod2_in;
   logic                 neg2_ff, active2_ff, done2_ff;
   // stage 3: result register
   logic                       v3_ff;
   logic signed [SAMPLE_W-1:0] sample3_ff, sample3_in;
   logic                       done3_ff;

   logic                 s2_ready, s3_ready;
   logic [MAG_W-1:0]     mag1;
   logic [SCALED_W-1:0]  scaled;

   assign s3_ready = !v3_ff || rsp_ch.ready;
   assign s2_ready = !v2_ff || s3_ready;
   assign s1_ready = !v1_ff || s2_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s1_ready) v1_ff <= in_valid;
         if (s2_ready) v2_ff <= v1_ff;
         if (s3_ready) v3_ff <= v2_ff;
      end
   end

   assign mag1     = sine[SAMPLE_W-1] ? MAG_W'(-sine) : sine[MAG_W-1:0];
   assign prod2_in = {{LEVEL_W{1'b0}}, mag1} * {{MAG_W{1'b0}}, level1_ff};

   assign scaled = prod2_ff[PROD_W-1:PROD_SHIFT];

   always_comb begin
      if (!active2_ff) begin
         sample3_in = '0;
      end else if (neg2_ff) begin
         sample3_in = (scaled > NEG_LIMIT) ? SAMPLE_MIN : -$signed(SAMPLE_W'(scaled));
      end else begin
         sample3_in = (scaled > POS_LIMIT) ? SAMPLE_MAX : $signed(SAMPLE_W'(scaled));
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         level1_ff  <= front.level;
         active1_ff <= front.active;
         done1_ff   <= front.done;
      end
      if (s2_ready) begin
         prod2_ff   <= prod2_in;
         neg2_ff    <= sine[SAMPLE_W-1];
         active2_ff <= active1_ff;
         done2_ff   <= done1_ff;
      end
      if (s3_ready) begin
         sample3_ff <= sample3_in;
         done3_ff   <= done2_ff;
      end
   end

   assign rsp_ch.valid     = v3_ff;
   assign rsp_ch.sample    = sample3_ff;
   assign rsp_ch.note_done = done3_ff;

endmodule

// ===== rtl/sine_tone_envelope_synth_unit.sv =====
// after its req_ch transfer a tick passes these registered stages to rsp_ch:
// (envelope update into the table read, multiply, saturate into the result register)
// throughput: one tick per cycle; the table read and the product are one stage each
// a stalled response holds only full stages; req_ch waits only when all are full
// reset clears phase, counter, level, note state and the pipeline valids,
// and loads note_length 20000, env_step 307, start_level 307
// ----------------------------------------------------------------------------
// sine_tone_envelope_synth_unit
// Sine tone generator: phase accumulator into a sine table, scaled by a
// four-phase envelope, one sample per tick.
// ----------------------------------------------------------------------------
module sine_tone_envelope_synth_unit import sts_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   sts_req_if.sink                req_ch,
   sts_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic                       s1_ready;
   logic                       req_accept;
   sts_front_type              front;
   logic signed [SAMPLE_W-1:0] sine_rd;

   assign req_ch.ready = s1_ready;
   assign req_accept   = req_ch.valid && s1_ready;

   sts_envelope u_envelope (
      .clock      (clock),
      .reset      (reset),
      .accept     (req_accept),
      .note_start (req_ch.note_start),
      .phase_step (req_ch.phase_step),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .front      (front)
   );

   sts_sine_rom u_sine_rom (
      .clock   (clock),
      .rd_en   (s1_ready),
      .addr    (front.addr),
      .rd_data (sine_rd)
   );

   sts_scale u_scale (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .front    (front),
      .sine     (sine_rd),
      .s1_ready (s1_ready),
      .rsp_ch   (rsp_ch)
   );

endmodule

// ===== rtl/sts_checker.sv =====
// ----------------------------------------------------------------------------
// sts_checker
// Port-level checks of the synthesizer: response hold, in-flight count
// against the pipe depth, and readiness when the result register is empty.
// ----------------------------------------------------------------------------
module sts_checker import sts_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample,
   input logic                       rsp_note_done
);

   logic [PIPE_CNT_W-1:0] inflight_ff, inflight_in;

   assign inflight_in = inflight_ff
                      + PIPE_CNT_W'(req_valid && req_ready)
                      - PIPE_CNT_W'(rsp_valid && rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= '0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sample) && $stable(rsp_note_done))
      else $error("response changed while stalled");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty result register");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != '0)
      else $error("response with no transfer in flight");

   a_depth: assert property (@(posedge clock) disable iff (reset)
      inflight_ff <= PIPE_CNT_W'(PIPE_DEPTH))
      else $error("more transfers in flight than pipeline stages");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind sine_tone_envelope_synth_unit sts_checker u_sts_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_ch.valid),
   .req_ready     (req_ch.ready),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_sample    (rsp_ch.sample),
   .rsp_note_done (rsp_ch.note_done)
);

// ===== tb/sts_tone_check.sv =====
// ----------------------------------------------------------------------------
// sts_tone_check
// Watches the tick and sample channels and the register port, keeps its own
// tone generator state, predicts every sample and compares it on transfer.
// ----------------------------------------------------------------------------
module sts_tone_check import sts_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   sts_req_if                     req_mon,
   sts_rsp_if                     rsp_mon,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int unsigned            fail_count,
   output int unsigned            pending,
   output int unsigned            checked_count,
   output int unsigned            note_ends
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       note_done;
   } tone_result_type;

   logic signed [SAMPLE_W-1:0] sine_rom [SINE_ENTRIES];

   // generator state
   logic [PHASE_BITS-1:0]   tone_phase;
   logic [PHASE_STEP_W-1:0] tone_incr;
   logic [CFG_W-1:0]        tone_index;
   logic [LEVEL_W-1:0]      tone_level;
   logic                    tone_on;

   // register copies
   logic [CFG_W-1:0] cfg_note_length;
   logic [CFG_W-1:0] cfg_env_step;
   logic [CFG_W-1:0] cfg_start_level;

   tone_result_type tone_q [$];

   // q1.15 sine from a q30 angle, folded into the first quadrant
   function automatic logic signed [SAMPLE_W-1:0] sine_entry(input int unsigned k);
      longint unsigned ang;
      longint unsigned sq;
      longint unsigned term;
      longint unsigned rounded;
      longint          acc;
      logic            negative;
      logic signed [SAMPLE_W-1:0] mag16;
      int              n;
      ang      = (64'(k) * TWO_PI_Q30) / 64'(SINE_ENTRIES);
      negative = (ang >= PI_Q30);
      if (negative) begin
         ang = ang - PI_Q30;
      end
      if (ang > PI_Q30 / 2) begin
         ang = PI_Q30 - ang;
      end
      sq   = (ang * ang) >> 30;
      term = ang;
      acc  = ang;
      for (n = 1; n <= SINE_TERMS; n++) begin
         term = ((term * sq) >> 30) / 64'((2 * n) * (2 * n + 1));
         if (n[0]) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      rounded = acc;
      rounded = (rounded + 64'd16384) >> 15;
      if (rounded > 64'd32767) begin
         rounded = 64'd32767;
      end
      mag16 = SAMPLE_W'(rounded);
      return negative ? -mag16 : mag16;
   endfunction

   initial begin
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         sine_rom[k] = sine_entry(k);
      end
   end

   // magnitude is scaled so the result truncates toward zero
   function automatic logic signed [SAMPLE_W-1:0] scaled_sample();
      logic [SINE_BITS-1:0]       addr;
      logic signed [SAMPLE_W-1:0] s;
      longint unsigned            mag;
      logic                       neg;
      addr = tone_phase[PHASE_BITS-1 -: SINE_BITS];
      s    = sine_rom[addr];
      neg  = (s < 0);
      mag  = neg ? 64'(-int'(s)) : 64'(int'(s));
      mag  = (mag * 64'(tone_level)) >> PROD_SHIFT;
      if (neg) begin
         return (mag > 64'd32768) ? SAMPLE_MIN : -$signed(SAMPLE_W'(mag));
      end
      return (mag > 64'd32767) ? SAMPLE_MAX : $signed(SAMPLE_W'(mag));
   endfunction

   function automatic void drop_level();
      logic [CFG_W-1:0] half;
      half       = cfg_env_step >> 1;
      tone_level = (tone_level > LEVEL_W'(half)) ? tone_level - LEVEL_W'(half) : '0;
   endfunction

   function automatic tone_result_type next_tone(input logic start,
                                                 input logic [PHASE_STEP_W-1:0] step);
      tone_result_type r;
      int unsigned     len;
      int unsigned     i;
      longint unsigned raised;
      if (start) begin
         tone_incr  = step;
         tone_phase = '0;
         tone_index = '0;
         tone_level = LEVEL_W'(cfg_start_level);
         tone_on    = 1'b1;
      end
      r = '0;
      if (!tone_on) begin
         return r;
      end
      len = cfg_note_length;
      i   = tone_index;
      if (i <= len / 4) begin
         r.sample   = scaled_sample();
         raised     = 64'(tone_level) + 64'(cfg_env_step);
         tone_level = (raised > 64'(LEVEL_MAX)) ? LEVEL_MAX : LEVEL_W'(raised);
      end else if (i <= len / 2) begin
         drop_level();
         r.sample = scaled_sample();
      end else if (i <= (len * 3) / 4) begin
         r.sample = scaled_sample();
      end else begin
         drop_level();
         r.sample = scaled_sample();
      end
      r.note_done = (i >= len);
      if (r.note_done) begin
         tone_on = 1'b0;
      end else begin
         tone_index = tone_index + 1'b1;
      end
      tone_phase = tone_phase + tone_incr;
      return r;
   endfunction

   task automatic report_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t mismatch: %s", $time, msg);
      end
   endtask

   always @(posedge clock) begin : monitor
      tone_result_type want;
      if (reset) begin
         tone_phase      = '0;
         tone_incr       = '0;
         tone_index      = '0;
         tone_level      = '0;
         tone_on         = 1'b0;
         cfg_note_length = NOTE_LENGTH_RST;
         cfg_env_step    = ENV_STEP_RST;
         cfg_start_level = START_LEVEL_RST;
         tone_q.delete();
         fail_count      = 0;
         checked_count   = 0;
         note_ends       = 0;
      end else begin
         // an item accepted at this edge cannot leave at the same edge
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (tone_q.size() == 0) begin
               report_mismatch($sformatf("sample %0d with no tick outstanding",
                                         rsp_mon.sample));
            end else begin
               want = tone_q.pop_front();
               checked_count++;
               if (want.sample !== rsp_mon.sample) begin
                  report_mismatch($sformatf("sample %0d: got %0d, predicted %0d",
                                            checked_count, rsp_mon.sample,
                                            $signed(want.sample)));
               end
               if (want.note_done !== rsp_mon.note_done) begin
                  report_mismatch($sformatf("sample %0d: note_done %b, predicted %b",
                                            checked_count, rsp_mon.note_done,
                                            want.note_done));
               end
               if (rsp_mon.note_done === 1'b1) begin
                  note_ends++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            tone_q.insert(tone_q.size(), next_tone(req_mon.note_start, req_mon.phase_step));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_NOTE_LENGTH: cfg_note_length = csr_wdata;
               CSR_ENV_STEP:    cfg_env_step    = csr_wdata;
               CSR_START_LEVEL: cfg_start_level = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = tone_q.size();
   end

endmodule

// ===== tb/sine_tone_envelope_synth_unit_tb.sv =====
// ----------------------------------------------------------------------------
// sine_tone_envelope_synth_unit_tb
// Drives directed and random ticks through the tone generator under random
// back-pressure, reprograms the envelope registers between phases and lets
// the companion checker predict and compare every sample.
// ----------------------------------------------------------------------------
module sine_tone_envelope_synth_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sts_pkg::*;

   localparam int unsigned ITEM_TARGET = 1400;
   localparam int unsigned IDLE_LIMIT  = 1000;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   typedef enum logic [1:0] {
      PHASE_SHORT,
      PHASE_EXTREME,
      PHASE_LONG
   } phase_kind_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   sts_req_if req_ch ();
   sts_rsp_if rsp_ch ();

   int unsigned fail_count;
   int unsigned pending;
   int unsigned checked_count;
   int unsigned note_ends;
   int unsigned ticks_sent;
   int unsigned settings_loaded;
   int unsigned idle_cycles;
   logic [CFG_W-1:0] cur_len;
   bit quiet;

   sine_tone_envelope_synth_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sts_tone_check tone_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .checked_count (checked_count),
      .note_ends     (note_ends)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly no gap, some short, a few long
   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (quiet) begin
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 75) begin
         return 0;
      end
      if (roll < 96) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [PHASE_STEP_W-1:0] pick_step();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2, 3:    return PHASE_STEP_W'($urandom_range(0, 32'h00FF_FFFF));
         default: return PHASE_STEP_W'($urandom());
      endcase
   endfunction

   // called and returns at a falling edge
   task automatic send_tick(input logic start, input logic [PHASE_STEP_W-1:0] step);
      int unsigned gap;
      req_ch.valid      <= 1'b1;
      req_ch.note_start <= start;
      req_ch.phase_step <= step;
      do @(posedge clock); while (!req_ch.ready);
      ticks_sent++;
      @(negedge clock);
      gap = pick_gap();
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic play_note(input logic [PHASE_STEP_W-1:0] step, input int unsigned ticks);
      send_tick(1'b1, step);
      repeat (ticks) send_tick(1'b0, pick_step());
   endtask

   task automatic hold_until_empty();
      req_ch.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic drain_pipe();
      hold_until_empty();
      repeat (PIPE_DEPTH + 2) @(negedge clock);
   endtask

   task automatic load_settings(input logic [CFG_W-1:0] len, input logic [CFG_W-1:0] step,
                                input logic [CFG_W-1:0] lvl, input bit poke_spare);
      csr_we    <= 1'b1;
      csr_index <= CSR_NOTE_LENGTH;
      csr_wdata <= len;
      @(negedge clock);
      csr_index <= CSR_ENV_STEP;
      csr_wdata <= step;
      @(negedge clock);
      csr_index <= CSR_START_LEVEL;
      csr_wdata <= lvl;
      @(negedge clock);
      if (poke_spare) begin
         // writes to the unused index must leave every register alone
         csr_index <= CSR_SPARE;
         csr_wdata <= CSR_DATA_W'($urandom());
         @(negedge clock);
      end
      csr_we <= 1'b0;
      cur_len = len;
      settings_loaded++;
   endtask

   initial begin : rsp_drive
      int unsigned stall;
      stall        = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall != 0) begin
            rsp_ch.ready <= 1'b0;
            stall--;
         end else begin
            rsp_ch.ready <= 1'b1;
            stall = pick_gap();
         end
      end
   end

   // counts cycles without any transfer on either channel
   initial begin : watchdog
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("sine_tone_envelope_synth_unit_tb: errors");
      $finish;
   end

   initial begin : stimulus
      phase_kind_type   kind;
      int unsigned      budget;
      int unsigned      run;
      int unsigned      ticks;
      logic [CFG_W-1:0] len;
      reset             = 1'b1;
      csr_we            = 1'b0;
      csr_index         = CSR_NOTE_LENGTH;
      csr_wdata         = '0;
      req_ch.valid      = 1'b0;
      req_ch.note_start = 1'b0;
      req_ch.phase_step = '0;
      quiet             = 1'b0;
      ticks_sent        = 0;
      settings_loaded   = 0;
      cur_len           = NOTE_LENGTH_RST;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // idle ticks before any note
      send_tick(1'b0, '1);
      send_tick(1'b0, '0);
      send_tick(1'b0, PHASE_STEP_W'($urandom()));

      // zero length note with all-ones register values, then idle again
      drain_pipe();
      load_settings(16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
      send_tick(1'b1, '1);
      send_tick(1'b0, PHASE_STEP_W'($urandom()));

      // short note with a silent envelope
      drain_pipe();
      load_settings(16'd1, 16'd0, 16'd0, 1'b0);
      play_note(32'h8000_0000, 1);

      // quarter-turn steps hit the sine peaks; note runs into the first fall
      drain_pipe();
      load_settings(16'd40, 16'd900, 16'hFFFF, 1'b0);
      play_note(32'h4000_0000, 14);

      // a huge step mid-note drives the falling level down to zero
      drain_pipe();
      load_settings(16'd40, 16'hFFFF, 16'hFFFF, 1'b0);
      repeat (3) send_tick(1'b0, pick_step());

      // length lowered below the running index ends the note at once
      drain_pipe();
      load_settings(16'd4, ENV_STEP_RST, START_LEVEL_RST, 1'b0);
      send_tick(1'b0, pick_step());
      send_tick(1'b0, pick_step());

      // first random phase saturates the level so samples clip
      kind = PHASE_LONG;
      while (ticks_sent < ITEM_TARGET) begin
         drain_pipe();
         quiet = ($urandom_range(0, 3) == 0);
         case (kind)
            PHASE_LONG: begin
               load_settings(CFG_W'($urandom_range(1060, 1100)),
                             CFG_W'($urandom_range(64000, 65535)),
                             CFG_W'($urandom_range(64000, 65535)), 1'b0);
               play_note(PHASE_STEP_W'($urandom_range(32'h0100_0000, 32'h0800_0000)), 299);
            end
            PHASE_EXTREME: begin
               case ($urandom_range(0, 3))
                  0:       len = 16'd4;
                  1:       len = 16'hFFFF;
                  2:       len = CFG_W'($urandom_range(0, 3));
                  default: len = CFG_W'($urandom_range(4, 12));
               endcase
               load_settings(len, $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                             $urandom_range(0, 1) ? 16'hFFFF : 16'h0000,
                             $urandom_range(0, 1) == 0);
            end
            default: begin
               if ($urandom_range(0, 9) == 0) begin
                  len = CFG_W'($urandom_range(0, 3));
               end else begin
                  len = CFG_W'($urandom_range(4, 48));
               end
               load_settings(len, CFG_W'($urandom()), CFG_W'($urandom()),
                             $urandom_range(0, 3) == 0);
            end
         endcase
         if (kind != PHASE_LONG) begin
            budget = $urandom_range(40, 120);
            run    = 0;
            while (run < budget) begin
               if ($urandom_range(0, 9) < 8) begin
                  // whole note, now and then cut short by a restart
                  ticks = cur_len;
                  if ($urandom_range(0, 5) == 0) begin
                     ticks = $urandom_range(0, ticks);
                  end
                  if (ticks > budget - run) begin
                     ticks = budget - run;
                  end
                  play_note(pick_step(), ticks);
                  run += ticks + 1;
                  repeat ($urandom_range(0, 2)) begin
                     send_tick(1'b0, pick_step());
                     run++;
                  end
               end else begin
                  send_tick($urandom_range(0, 3) == 0, pick_step());
                  run++;
               end
               if ($urandom_range(0, 29) == 0) begin
                  hold_until_empty();
               end
            end
         end
         kind = ($urandom_range(0, 4) == 0) ? PHASE_EXTREME : PHASE_SHORT;
      end

      drain_pipe();
      $display("covered %0d ticks over %0d register settings: idle, restarts, notes, clipping",
               ticks_sent, settings_loaded);
      $display("%0d samples compared, %0d note ends seen", checked_count, note_ends);
      if (fail_count == 0 && pending == 0) begin
         $display("sine_tone_envelope_synth_unit_tb: clean");
      end else begin
         $display("sine_tone_envelope_synth_unit_tb: errors");
      end
      $finish;
   end

endmodule

// ===== sine_tone_envelope_synth_unit.f =====
rtl/sts_pkg.sv
rtl/sts_if.sv
rtl/sts_envelope.sv
rtl/sts_sine_rom.sv
rtl/sts_scale.sv
rtl/sine_tone_envelope_synth_unit.sv
rtl/sts_checker.sv
tb/sts_tone_check.sv
tb/sine_tone_envelope_synth_unit_tb.sv
